// File: rtl/core/psa_pkg.sv
// Package for the priority scheduler with aging.
// Holds field widths, operation and status codes, level types and the compare result.
// No dependencies.
package psa_pkg;

    localparam int LEVEL_W = 6;
    localparam int SLOT_W  = 4;

    typedef logic signed [LEVEL_W-1:0] level_t;
    typedef logic [SLOT_W-1:0]         slot_t;
    typedef logic [1:0]                op_t;
    typedef logic [1:0]                status_t;

    localparam op_t OP_ADD    = 2'd0;
    localparam op_t OP_REMOVE = 2'd1;
    localparam op_t OP_SETPRI = 2'd2;
    localparam op_t OP_PICK   = 2'd3;

    localparam status_t ST_OK          = 2'd0;
    localparam status_t ST_NOT_PRESENT = 2'd1;
    localparam status_t ST_PRESENT     = 2'd2;
    localparam status_t ST_EMPTY       = 2'd3;

    localparam level_t FLOOR_RESET = -6'sd20;

    // One table entry: static and dynamic priority
    typedef struct packed {
        level_t stat;
        level_t dyn;
    } level_pair_t;

    // Verdict of the compare and aging unit for one scanned entry
    typedef struct packed {
        logic   better;
        logic   age_en;
        level_t aged;
    } cmp_res_t;

endpackage

// File: rtl/core/psa_if.sv
// Channel interfaces of the priority scheduler: request, response and configuration.
// Depends on psa_pkg.
interface psa_req_if;
    import psa_pkg::*;
    logic   valid;
    logic   ready;
    op_t    operation;
    slot_t  task_slot;
    level_t priority_req;

    modport source (output valid, operation, task_slot, priority_req, input ready);
    modport sink   (input valid, operation, task_slot, priority_req, output ready);
endinterface

interface psa_rsp_if;
    import psa_pkg::*;
    logic    valid;
    logic    ready;
    status_t status;
    slot_t   chosen_task;
    level_t  chosen_priority;

    modport source (output valid, status, chosen_task, chosen_priority, input ready);
    modport sink   (input valid, status, chosen_task, chosen_priority, output ready);
endinterface

interface psa_cfg_if;
    import psa_pkg::*;
    logic   valid;
    logic   ready;
    level_t aging_floor;

    modport source (output valid, aging_floor, input ready);
    modport sink   (input valid, aging_floor, output ready);
endinterface

// File: rtl/core/psa_age_cmp.sv
// Shared compare and aging unit: ranks one scanned entry against the running best
// and computes its aged dynamic priority. Depends on psa_pkg.
module psa_age_cmp (
    input  psa_pkg::level_pair_t cand,
    input  psa_pkg::level_pair_t best,
    input  logic                 best_valid,
    input  psa_pkg::level_t      floor_lvl,
    output psa_pkg::cmp_res_t    res
);
    import psa_pkg::*;

    // Rank by dynamic priority, then static; equal keeps the earlier slot
    always_comb
    begin
        res.better = !best_valid
                     || (cand.dyn < best.dyn)
                     || ((cand.dyn == best.dyn) && (cand.stat < best.stat));
        res.age_en = cand.dyn > floor_lvl;
        res.aged   = cand.dyn - level_t'(1);
    end

endmodule

// File: rtl/core/priority_scheduler_with_aging_top.sv
// Priority scheduler with aging, top level.
// Holds the slot table, the scan sequencer and the response register.
// Depends on psa_pkg, psa_if and psa_age_cmp.
//
// Usage:
//   req  : one request per handshake (operation, task_slot, priority_req).
//   rsp  : exactly one response per request, in request order.
//   cfg  : writes aging_floor; always ready; write only while the block is idle.
// Sequence:
//   Add, remove and set priority are executed in the exec state and answered from
//   the response register; the next request is taken once the block is idle again.
//   A pick makes one registered read of the level memory per slot through the shared
//   compare and aging unit, drains the read stage, then writes back the winner as its
//   response is loaded; a new request is taken only after the pick has responded.
// Stall:
//   A response waits in its register until taken; the next request is still
//   accepted, and its own response holds in the sequencer until the register frees.
// Reset:
//   Clears all present bits and the response valid flag and sets aging_floor to
//   -20; no clearing pass, level memory entries are only ranked for present slots.
module priority_scheduler_with_aging_top #(
    parameter int MAX_TASKS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    psa_req_if.sink      req,
    psa_rsp_if.source    rsp,
    psa_cfg_if.sink      cfg
);
    import psa_pkg::*;

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    // Control state
    logic [1:0]           state_reg, state_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic                 p_valid_reg, p_valid_next;
    logic [IDX_W-1:0]     p_idx_reg, p_idx_next;
    logic                 best_valid_reg, best_valid_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    level_pair_t          best_reg, best_next;
    logic [MAX_TASKS-1:0] present_reg, present_next;
    level_t               floor_reg, floor_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    status_t              status_reg, status_next;
    slot_t                chosen_task_reg, chosen_task_next;
    level_t               chosen_prio_reg, chosen_prio_next;

    // Latched request
    op_t                  op_reg, op_next;
    slot_t                slot_reg, slot_next;
    level_t               prio_reg, prio_next;

    // Level memory
    level_pair_t          mem [MAX_TASKS];
    level_pair_t          rd_data_reg;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    level_pair_t          mem_wdata;
    logic                 issue;

    logic                 out_free;
    logic                 in_range;
    logic [IDX_W-1:0]     slot_idx;
    cmp_res_t             cmp;

    assign req.ready           = (state_reg == S_IDLE);
    assign cfg.ready           = 1'b1;
    assign rsp.valid           = rsp_valid_reg;
    assign rsp.status          = status_reg;
    assign rsp.chosen_task     = chosen_task_reg;
    assign rsp.chosen_priority = chosen_prio_reg;

    assign out_free = !rsp_valid_reg || rsp.ready;
    assign in_range = (32'(slot_reg) < MAX_TASKS);
    assign slot_idx = IDX_W'(slot_reg);
    assign issue    = (state_reg == S_SCAN) && (idx_reg != CNT_W'(MAX_TASKS));

    psa_age_cmp u_cmp (
        .cand       (rd_data_reg),
        .best       (best_reg),
        .best_valid (best_valid_reg),
        .floor_lvl  (floor_reg),
        .res        (cmp)
    );

    // Sequencer and response
    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        p_valid_next     = issue;
        p_idx_next       = issue ? IDX_W'(idx_reg) : p_idx_reg;
        best_valid_next  = best_valid_reg;
        best_idx_next    = best_idx_reg;
        best_next        = best_reg;
        present_next     = present_reg;
        floor_next       = cfg.valid ? cfg.aging_floor : floor_reg;
        rsp_valid_next   = (rsp_valid_reg && rsp.ready) ? 1'b0 : rsp_valid_reg;
        status_next      = status_reg;
        chosen_task_next = chosen_task_reg;
        chosen_prio_next = chosen_prio_reg;
        op_next          = op_reg;
        slot_next        = slot_reg;
        prio_next        = prio_reg;
        mem_we           = 1'b0;
        mem_waddr        = slot_idx;
        mem_wdata        = '{stat: prio_reg, dyn: prio_reg};

        // Rank and age the entry read last cycle
        if (p_valid_reg && present_reg[p_idx_reg])
        begin
            if (cmp.better)
            begin
                best_valid_next = 1'b1;
                best_idx_next   = p_idx_reg;
                best_next       = rd_data_reg;
            end
            if (cmp.age_en)
            begin
                mem_we    = 1'b1;
                mem_waddr = p_idx_reg;
                mem_wdata = '{stat: rd_data_reg.stat, dyn: cmp.aged};
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next         = req.operation;
                    slot_next       = req.task_slot;
                    prio_next       = req.priority_req;
                    idx_next        = '0;
                    best_valid_next = 1'b0;
                    state_next      = (req.operation == OP_PICK) ? S_SCAN : S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    rsp_valid_next   = 1'b1;
                    status_next      = ST_OK;
                    chosen_task_next = '0;
                    chosen_prio_next = '0;
                    state_next       = S_IDLE;
                    priority if (!in_range)
                        status_next = ST_NOT_PRESENT;
                    else if (op_reg == OP_ADD)
                    begin
                        if (present_reg[slot_idx])
                            status_next = ST_PRESENT;
                        else
                        begin
                            present_next[slot_idx] = 1'b1;
                            mem_we                 = 1'b1;
                        end
                    end
                    else if (!present_reg[slot_idx])
                        status_next = ST_NOT_PRESENT;
                    else if (op_reg == OP_REMOVE)
                        present_next[slot_idx] = 1'b0;
                    else
                        mem_we = 1'b1;
                end
            end
            S_SCAN:
            begin
                if (issue)
                    idx_next = idx_reg + CNT_W'(1);
                else
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (best_valid_reg)
                    begin
                        status_next      = ST_OK;
                        chosen_task_next = SLOT_W'(best_idx_reg);
                        chosen_prio_next = best_reg.stat;
                        mem_we           = 1'b1;
                        mem_waddr        = best_idx_reg;
                        mem_wdata        = '{stat: best_reg.stat, dyn: best_reg.stat};
                    end
                    else
                    begin
                        status_next      = ST_EMPTY;
                        chosen_task_next = '0;
                        chosen_prio_next = '0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            p_valid_reg    <= 1'b0;
            best_valid_reg <= 1'b0;
            present_reg    <= '0;
            floor_reg      <= FLOOR_RESET;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            p_valid_reg    <= p_valid_next;
            best_valid_reg <= best_valid_next;
            present_reg    <= present_next;
            floor_reg      <= floor_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        p_idx_reg       <= p_idx_next;
        best_idx_reg    <= best_idx_next;
        best_reg        <= best_next;
        status_reg      <= status_next;
        chosen_task_reg <= chosen_task_next;
        chosen_prio_reg <= chosen_prio_next;
        op_reg          <= op_next;
        slot_reg        <= slot_next;
        prio_reg        <= prio_next;
    end

    // Level memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (issue)
            rd_data_reg <= mem[IDX_W'(idx_reg)];
    end

`ifndef SYNTH
    a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        p_valid_reg |-> (state_reg == S_SCAN))
        else $error("scan read stage active outside scan");

    a_winner_present: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_FINISH) && best_valid_reg) |-> present_reg[best_idx_reg])
        else $error("pick winner is not a present slot");

    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == S_EXEC || $past(state_reg) == S_FINISH))
        else $error("response loaded outside exec or finish");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (idx_reg <= CNT_W'(MAX_TASKS)))
        else $error("scan index beyond table");
`endif

endmodule

// File: verif/priority_scheduler_with_aging_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for priority_scheduler_with_aging_top: a shadow scheduler
// predicts every response to directed and random requests. Depends on psa_pkg, psa_if and the RTL.
module priority_scheduler_with_aging_top_tb;
    import psa_pkg::*;

    localparam int SLOTS        = 16;
    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 5;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 205;
    localparam int RSP_HOLD_LEN = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        op_t    op;
        slot_t  slot;
        level_t prio;
    } sched_req_t;

    typedef struct packed {
        status_t status;
        slot_t   task_id;
        level_t  prio;
    } sched_rsp_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    psa_req_if req_ch();
    psa_rsp_if rsp_ch();
    psa_cfg_if cfg_ch();

    priority_scheduler_with_aging_top #(
        .MAX_TASKS (SLOTS)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Shadow copy of the slot table and the aging floor
    bit     model_present [SLOTS];
    level_t model_static  [SLOTS];
    level_t model_dynamic [SLOTS];
    level_t model_floor = FLOOR_RESET;

    // Presence as seen by the request generator, to build well-formed sequences
    bit gen_present [SLOTS];

    sched_req_t req_backlog[$];
    sched_rsp_t due_responses[$];

    int   queued_count   = 0;
    int   accepted_count = 0;
    int   rsp_count      = 0;
    int   error_count    = 0;
    int   op_count [4]   = '{default: 0};
    int   picks_won      = 0;
    int   picks_empty    = 0;
    int   floor_writes   = 0;
    int   cycle_count    = 0;
    int   req_idle_pct   = 0;
    int   rsp_idle_pct   = 0;
    bit   req_hold       = 1'b0;
    int   holds_asked    = 0;
    int   holds_served   = 0;
    int   hold_left      = 0;
    logic req_fire       = 1'b0;
    logic cfg_fire       = 1'b0;

    sched_req_t issue_req;
    sched_req_t seen_req;
    sched_rsp_t seen_rsp;
    sched_rsp_t want_rsp;

    always #CLK_HALF clk = ~clk;

    // Apply one request to the shadow table and return the response it earns
    function automatic sched_rsp_t run_scheduler_op(sched_req_t r);
        sched_rsp_t res;
        int         best;
        res  = '0;
        best = -1;
        case (r.op)
            OP_PICK:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (model_present[i] && (best < 0 ||
                        model_dynamic[i] < model_dynamic[best] ||
                        (model_dynamic[i] == model_dynamic[best] &&
                         model_static[i] < model_static[best])))
                        best = i;
                end
                if (best < 0)
                    res.status = ST_EMPTY;
                else
                begin
                    // Age every other present slot, stop at the floor
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (model_present[i] && i != best && model_dynamic[i] > model_floor)
                            model_dynamic[i] = model_dynamic[i] - level_t'(1);
                    end
                    model_dynamic[best] = model_static[best];
                    res.status  = ST_OK;
                    res.task_id = slot_t'(best);
                    res.prio    = model_static[best];
                end
            end
            OP_ADD:
            begin
                if (model_present[r.slot])
                    res.status = ST_PRESENT;
                else
                begin
                    model_present[r.slot] = 1'b1;
                    model_static[r.slot]  = r.prio;
                    model_dynamic[r.slot] = r.prio;
                end
            end
            default:
            begin
                if (!model_present[r.slot])
                    res.status = ST_NOT_PRESENT;
                else if (r.op == OP_REMOVE)
                    model_present[r.slot] = 1'b0;
                else
                begin
                    model_static[r.slot]  = r.prio;
                    model_dynamic[r.slot] = r.prio;
                end
            end
        endcase
        return res;
    endfunction

    function automatic void flag_error(string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    // Sample handshakes, check responses, predict accepted requests
    always @(posedge clk)
    begin
        req_fire <= rst_n && req_ch.valid && req_ch.ready;
        cfg_fire <= rst_n && cfg_ch.valid && cfg_ch.ready;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                seen_rsp.status  = rsp_ch.status;
                seen_rsp.task_id = rsp_ch.chosen_task;
                seen_rsp.prio    = rsp_ch.chosen_priority;
                rsp_count++;
                if (due_responses.size() == 0)
                    flag_error($sformatf("response %0d arrived with no request waiting",
                                         rsp_count));
                else
                begin
                    want_rsp = due_responses.pop_front();
                    if (seen_rsp.status !== want_rsp.status ||
                        seen_rsp.task_id !== want_rsp.task_id ||
                        seen_rsp.prio !== want_rsp.prio)
                        flag_error($sformatf(
                            "response %0d: want status %0d task %0d prio %0d, got %0d %0d %0d",
                            rsp_count, want_rsp.status, want_rsp.task_id, want_rsp.prio,
                            seen_rsp.status, seen_rsp.task_id, seen_rsp.prio));
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                seen_req.op   = req_ch.operation;
                seen_req.slot = req_ch.task_slot;
                seen_req.prio = req_ch.priority_req;
                want_rsp = run_scheduler_op(seen_req);
                op_count[seen_req.op]++;
                if (seen_req.op == OP_PICK && want_rsp.status == ST_OK)
                    picks_won++;
                if (want_rsp.status == ST_EMPTY)
                    picks_empty++;
                accepted_count++;
                due_responses.push_back(want_rsp);
            end
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                model_floor = cfg_ch.aging_floor;
                floor_writes++;
            end
        end
    end

    // Drive requests from the backlog; hold the current one until taken
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req_ch.valid        <= 1'b0;
            req_ch.operation    <= OP_ADD;
            req_ch.task_slot    <= '0;
            req_ch.priority_req <= '0;
        end
        else if (!req_ch.valid || req_fire)
        begin
            if (req_hold || req_backlog.size() == 0 || $urandom_range(99) < req_idle_pct)
                req_ch.valid <= 1'b0;
            else
            begin
                issue_req = req_backlog.pop_front();
                req_ch.valid        <= 1'b1;
                req_ch.operation    <= issue_req.op;
                req_ch.task_slot    <= issue_req.slot;
                req_ch.priority_req <= issue_req.prio;
            end
        end
    end

    // Count down a long receiver hold-off when one is asked for
    always @(negedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (holds_served != holds_asked)
        begin
            hold_left    <= RSP_HOLD_LEN;
            holds_served <= holds_served + 1;
        end
    end

    // Drive response ready with random stalls
    always @(negedge clk)
    begin
        if (!rst_n || hold_left != 0)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses outstanding",
                     cycle_count, due_responses.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic queue_req(input op_t op, input slot_t slot, input level_t prio);
        sched_req_t r;
        r.op   = op;
        r.slot = slot;
        r.prio = prio;
        req_backlog.push_back(r);
        queued_count++;
        if (op == OP_ADD)
            gen_present[slot] = 1'b1;
        else if (op == OP_REMOVE)
            gen_present[slot] = 1'b0;
    endtask

    // Prefer a slot in the wanted state, fall back to any slot
    function automatic slot_t choose_slot(input bit want_present);
        slot_t s;
        s = slot_t'($urandom_range(SLOTS - 1));
        for (int k = 0; k < 2 * SLOTS && gen_present[s] != want_present; k++)
            s = slot_t'($urandom_range(SLOTS - 1));
        return s;
    endfunction

    // Mostly in the nominal range, sometimes any 6-bit code
    function automatic level_t random_level();
        if ($urandom_range(99) < 85)
            return level_t'(int'($urandom_range(40)) - 20);
        return level_t'($urandom_range(63));
    endfunction

    task automatic queue_random(input int count, input int add_pct, input int drop_pct);
        int roll;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(99);
            if (roll < 10)
                queue_req(op_t'($urandom_range(3)), slot_t'($urandom_range(SLOTS - 1)),
                          level_t'($urandom_range(63)));
            else if (roll < 10 + add_pct)
                queue_req(OP_ADD, choose_slot(1'b0), random_level());
            else if (roll < 10 + add_pct + drop_pct)
                queue_req(OP_REMOVE, choose_slot(1'b1), random_level());
            else if (roll < 22 + add_pct + drop_pct)
                queue_req(OP_SETPRI, choose_slot(1'b1), random_level());
            else
                queue_req(OP_PICK, slot_t'($urandom_range(SLOTS - 1)),
                          level_t'($urandom_range(63)));
        end
    endtask

    // Return once every queued request is taken and answered
    task automatic wait_drained();
        do
            @(negedge clk);
        while (accepted_count != queued_count || due_responses.size() != 0);
    endtask

    task automatic write_floor(input level_t value);
        @(negedge clk);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.aging_floor <= value;
        do
            @(negedge clk);
        while (!cfg_fire);
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin
        level_t floor_plan [PHASES];
        int     pause_mark;
        floor_plan[0] = level_t'(20);
        floor_plan[1] = level_t'(-32);
        floor_plan[2] = level_t'(31);
        floor_plan[3] = level_t'(0);
        floor_plan[4] = level_t'(-20);
        floor_plan[5] = level_t'($urandom_range(63));

        cfg_ch.valid        = 1'b0;
        cfg_ch.aging_floor  = FLOOR_RESET;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty table, absent slots, out-of-range levels, ties, drain to empty
        @(posedge clk);
        queue_req(OP_PICK,   4'd0,  level_t'(0));
        queue_req(OP_REMOVE, 4'd3,  level_t'(0));
        queue_req(OP_SETPRI, 4'd3,  level_t'(7));
        queue_req(OP_ADD,    4'd0,  level_t'(-32));
        queue_req(OP_ADD,    4'd15, level_t'(31));
        queue_req(OP_ADD,    4'd0,  level_t'(5));
        queue_req(OP_ADD,    4'd5,  level_t'(-20));
        queue_req(OP_ADD,    4'd6,  level_t'(20));
        queue_req(OP_ADD,    4'd9,  level_t'(1));
        queue_req(OP_ADD,    4'd10, level_t'(1));
        queue_req(OP_PICK,   4'd0,  level_t'(0));
        queue_req(OP_SETPRI, 4'd0,  level_t'(31));
        queue_req(OP_PICK,   4'd0,  level_t'(0));
        queue_req(OP_PICK,   4'd0,  level_t'(0));
        queue_req(OP_REMOVE, 4'd5,  level_t'(0));
        queue_req(OP_PICK,   4'd0,  level_t'(0));
        queue_req(OP_PICK,   4'd0,  level_t'(0));
        queue_req(OP_SETPRI, 4'd15, level_t'(-21));
        queue_req(OP_PICK,   4'd0,  level_t'(0));
        queue_req(OP_REMOVE, 4'd0,  level_t'(0));
        queue_req(OP_REMOVE, 4'd6,  level_t'(0));
        queue_req(OP_REMOVE, 4'd9,  level_t'(0));
        queue_req(OP_REMOVE, 4'd10, level_t'(0));
        queue_req(OP_REMOVE, 4'd15, level_t'(0));
        queue_req(OP_PICK,   4'd0,  level_t'(0));
        wait_drained();

        // Random phases, each under its own floor; alternate filling and draining the table
        for (int p = 0; p < PHASES; p++)
        begin
            write_floor(floor_plan[p]);
            @(posedge clk);
            req_idle_pct = (p < 2) ? 28 : (p < 4) ? 78 : 0;
            rsp_idle_pct = (p < 2) ? 78 : (p < 4) ? 28 : 0;
            queue_random(PHASE_ITEMS, (p % 2 == 0) ? 30 : 12, (p % 2 == 0) ? 10 : 25);
            if (p == 1)
                holds_asked++;
            if (p == 3)
            begin
                // Stop sending halfway and let every response come back
                pause_mark = queued_count - PHASE_ITEMS / 2;
                do
                    @(negedge clk);
                while (accepted_count < pause_mark);
                @(posedge clk);
                req_hold = 1'b1;
                do
                    @(negedge clk);
                while (req_ch.valid || due_responses.size() != 0);
                @(posedge clk);
                req_hold = 1'b0;
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("covered %0d requests: %0d add, %0d remove, %0d set, %0d pick",
                 accepted_count, op_count[OP_ADD], op_count[OP_REMOVE],
                 op_count[OP_SETPRI], op_count[OP_PICK]);
        $display("%0d picks chose a slot, %0d found the table empty, %0d floor writes",
                 picks_won, picks_empty, floor_writes);
        if (error_count == 0 && due_responses.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
